### hw/rtl/lorc_pkg.sv
// ----------------------------------------------------------------------------
// lorc_pkg
// Shared widths, codes, CORDIC arctangent table and unit result types.
// ----------------------------------------------------------------------------
`default_nettype none

package lorc_pkg;

  localparam int unsigned XW = 34;  // CORDIC datapath, Q2.30 plus headroom
  localparam int unsigned NW = 36;  // divider numerator
  localparam int unsigned QW = 37;  // divider quotient (floor of signed value)
  localparam int unsigned SW = 22;  // scaled length after rounding

  localparam logic signed [XW-1:0] CordicGainQ30 = 34'sd652032874;

  localparam logic [2:0] CFG_CELL_SIZE  = 3'd0;
  localparam logic [2:0] CFG_MARCH_STEP = 3'd1;
  localparam logic [2:0] CFG_CORNER_X   = 3'd2;
  localparam logic [2:0] CFG_CORNER_Y   = 3'd3;
  localparam logic [2:0] CFG_FREE_UPD   = 3'd4;
  localparam logic [2:0] CFG_HIT_UPD    = 3'd5;
  localparam logic [2:0] CFG_FREE_THR   = 3'd6;
  localparam logic [2:0] CFG_HIT_THR    = 3'd7;

  localparam logic [1:0] REQ_RAY   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] CLS_FREE    = 2'd0;
  localparam logic [1:0] CLS_OCC     = 2'd1;
  localparam logic [1:0] CLS_UNKNOWN = 2'd2;

  typedef struct packed {
    logic                 done;
    logic signed [XW-1:0] cos_q30;
    logic signed [XW-1:0] sin_q30;
  } cordic_res_t;

  typedef struct packed {
    logic                 done;
    logic signed [QW-1:0] quot;
    logic        [15:0]   rem;
  } div_res_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [XW-1:0] lorc_atan(input logic [4:0] idx);
    logic signed [XW-1:0] v;
    case (idx)
      5'd0:  v = 34'sh020000000;
      5'd1:  v = 34'sh012E4051D;
      5'd2:  v = 34'sh009FB385B;
      5'd3:  v = 34'sh0051111D4;
      5'd4:  v = 34'sh0028B0D43;
      5'd5:  v = 34'sh00145D7E1;
      5'd6:  v = 34'sh000A2F61E;
      5'd7:  v = 34'sh000517C55;
      5'd8:  v = 34'sh00028BE53;
      5'd9:  v = 34'sh000145F2E;
      5'd10: v = 34'sh0000A2F98;
      5'd11: v = 34'sh0000517CC;
      5'd12: v = 34'sh000028BE6;
      5'd13: v = 34'sh0000145F3;
      5'd14: v = 34'sh00000A2F9;
      5'd15: v = 34'sh00000517C;
      5'd16: v = 34'sh0000028BE;
      5'd17: v = 34'sh00000145F;
      5'd18: v = 34'sh000000A2F;
      5'd19: v = 34'sh000000517;
      5'd20: v = 34'sh00000028B;
      5'd21: v = 34'sh000000145;
      5'd22: v = 34'sh0000000A2;
      5'd23: v = 34'sh000000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/lorc_ram.sv
// ----------------------------------------------------------------------------
// lorc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lorc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### hw/rtl/lorc_cordic.sv
// ----------------------------------------------------------------------------
// lorc_cordic
// Iterative rotation-mode CORDIC, one shift-add step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lorc_cordic import lorc_pkg::*; #(
  parameter int unsigned AngleIterations = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [15:0] angle_i,
  output cordic_res_t      res_o
);

  localparam int unsigned IW = $clog2(AngleIterations);

  logic                 busy_q, done_q;
  logic [IW-1:0]        iter_q;
  logic [1:0]           quad_q;
  logic signed [XW-1:0] x_q, y_q, z_q;
  logic signed [XW-1:0] sx, sy, atan_v;

  assign sx     = y_q >>> iter_q;
  assign sy     = x_q >>> iter_q;
  assign atan_v = lorc_atan(5'(iter_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        if (iter_q == IW'(AngleIterations - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        iter_q <= iter_q + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CordicGainQ30;
      y_q    <= '0;
      z_q    <= {4'b0, angle_i[13:0], 16'b0};
      quad_q <= angle_i[15:14];
    end else if (busy_q) begin
      if (!z_q[XW-1]) begin
        x_q <= x_q - sx;
        y_q <= y_q + sy;
        z_q <= z_q - atan_v;
      end else begin
        x_q <= x_q + sx;
        y_q <= y_q - sy;
        z_q <= z_q + atan_v;
      end
    end
  end

  always_comb begin
    res_o.done = done_q;
    case (quad_q)
      2'd0: begin
        res_o.cos_q30 = x_q;
        res_o.sin_q30 = y_q;
      end
      2'd1: begin
        res_o.cos_q30 = -y_q;
        res_o.sin_q30 = x_q;
      end
      2'd2: begin
        res_o.cos_q30 = -x_q;
        res_o.sin_q30 = -y_q;
      end
      default: begin
        res_o.cos_q30 = y_q;
        res_o.sin_q30 = -x_q;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/lorc_div.sv
// ----------------------------------------------------------------------------
// lorc_div
// Radix-2 restoring divider: signed numerator over unsigned 16-bit divisor,
// floor quotient and non-negative remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module lorc_div import lorc_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic signed [NW-1:0] num_i,
  input  wire logic        [15:0]   den_i,
  output div_res_t                  res_o
);

  localparam int unsigned CntW = $clog2(NW);

  logic            busy_q, done_q, neg_q;
  logic [CntW-1:0] cnt_q;
  logic [NW-1:0]   mag_q;
  logic [15:0]     rem_q, den_q;
  logic [16:0]     trial;
  logic            fit;

  assign trial = {rem_q, mag_q[NW-1]};
  assign fit   = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NW-1];
      mag_q <= num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      mag_q <= {mag_q[NW-2:0], fit};
      rem_q <= fit ? 16'(trial - {1'b0, den_q}) : trial[15:0];
    end
  end

  always_comb begin
    res_o.done = done_q;
    if (!neg_q) begin
      res_o.quot = QW'(mag_q);
      res_o.rem  = rem_q;
    end else if (rem_q == '0) begin
      res_o.quot = -QW'(mag_q);
      res_o.rem  = '0;
    end else begin
      res_o.quot = ~QW'(mag_q);
      res_o.rem  = den_q - rem_q;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/logodds_occupancy_ray_update_core.sv
// ----------------------------------------------------------------------------
// logodds_occupancy_ray_update_core
// Log-odds occupancy grid with ray-march updates, cell reads and clears.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (in_valid_i/in_ready_o): one transaction per request:
//    cast ray, read cell or clear grid. Result channel (out_valid_o /
//    out_ready_i): exactly one result transaction per request.
//  - Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i;
//    write only while the block is idle.
//  - One request is processed at a time; in_ready_o is high only when the
//    sequencer is idle.
//  - Ray: CORDIC, then the four length products, then the six cell-index
//    divisions on the shared divider, then the march steps (a RAM read,
//    then write, when a step enters a new in-grid cell), and finally the
//    endpoint.
//  - Clear: each of the GRID_COLS*GRID_ROWS cells is written to zero in turn.
//  - Reset: the grid RAM is swept to zero with in_ready_o low; config
//    writes are taken meanwhile.
//  - Output register: a finished result waits in it while the receiver
//    stalls; the next request is accepted, and its own result is held in the
//    sequencer until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module logodds_occupancy_ray_update_core import lorc_pkg::*; #(
  parameter int unsigned GRID_COLS        = 64,
  parameter int unsigned GRID_ROWS        = 64,
  parameter int unsigned ANGLE_ITERATIONS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         req_type_i,
  input  wire logic signed [31:0] origin_x_i,
  input  wire logic signed [31:0] origin_y_i,
  input  wire logic [15:0]        ray_angle_i,
  input  wire logic [16:0]        ray_range_i,
  input  wire logic [5:0]         query_col_i,
  input  wire logic [5:0]         query_row_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              cell_class_o,
  output logic signed [15:0]      cell_logodds_o,
  output logic                    endpoint_outside_o,
  output logic                    saturated_o
);

  localparam int unsigned Depth = GRID_COLS * GRID_ROWS;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = 40;  // marched cell coordinate

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_CORDIC, S_MUL, S_MULW, S_DIV_GO, S_DIV_WAIT,
    S_MARCH, S_MUPD, S_HIT, S_HUPD, S_READ, S_DONE
  } state_e;

  state_e state_q;

  // configuration
  logic [15:0]        cell_size_q, march_step_q;
  logic signed [31:0] corner_x_q, corner_y_q;
  logic signed [15:0] free_upd_q, hit_upd_q, free_thr_q, hit_thr_q;

  // request and working registers
  logic signed [31:0] ox_q, oy_q;
  logic [16:0]        range_q;
  logic               init_q;
  logic [AW-1:0]      clr_cnt_q, cur_addr_q;
  logic signed [XW-1:0] cos_q, sin_q;
  logic signed [51:0] prod_q;
  logic [1:0]         mul_cnt_q;
  logic [2:0]         div_cnt_q;
  logic signed [SW-1:0] dx_q, dy_q, ex_q, ey_q;
  logic signed [CW-1:0] col_q, row_q;
  logic [15:0]        remx_q, remy_q, rdx_q, rdy_q;
  logic signed [QW-1:0] qdx_q, qdy_q, ecol_q, erow_q;
  logic [17:0]        dist_q;
  logic               prev_valid_q;
  logic [AW-1:0]      prev_addr_q;
  logic [1:0]         res_class_q;
  logic signed [15:0] res_lo_q;
  logic               res_out_q, res_sat_q;

  // ---------------------------------------------------------------------------
  // Shared units
  // ---------------------------------------------------------------------------
  cordic_res_t cordic_res;
  div_res_t    div_res;
  logic        cordic_start, div_start;
  logic signed [NW-1:0] div_num;
  logic [15:0] size_eff, step_eff;

  assign size_eff = (cell_size_q == '0) ? 16'd1 : cell_size_q;
  assign step_eff = (march_step_q == '0) ? 16'd1 : march_step_q;

  // started on the accepting edge, so it takes the angle straight off the port
  lorc_cordic #(
    .AngleIterations(ANGLE_ITERATIONS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cordic_start),
    .angle_i(ray_angle_i),
    .res_o  (cordic_res)
  );

  always_comb begin
    case (div_cnt_q)
      3'd0: div_num = NW'(ox_q) - NW'(corner_x_q);
      3'd1: div_num = NW'(oy_q) - NW'(corner_y_q);
      3'd2: div_num = NW'(dx_q);
      3'd3: div_num = NW'(dy_q);
      3'd4: div_num = NW'(ox_q) + NW'(ex_q) - NW'(corner_x_q);
      3'd5: div_num = NW'(oy_q) + NW'(ey_q) - NW'(corner_y_q);
      default: div_num = '0;
    endcase
  end

  assign div_start = (state_q == S_DIV_GO);

  lorc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (size_eff),
    .res_o  (div_res)
  );

  // length scaling: each product is registered in S_MUL and rounded in S_MULW, before the next multiply
  logic signed [XW-1:0] mul_a;
  logic signed [17:0]   mul_b;
  logic signed [51:0]   prod_rnd;
  logic signed [SW-1:0] scaled;

  assign mul_a    = mul_cnt_q[0] ? sin_q : cos_q;
  assign mul_b    = mul_cnt_q[1] ? $signed({1'b0, range_q}) : $signed({2'b0, step_eff});
  assign prod_rnd = prod_q + 52'sh20000000;
  assign scaled   = prod_rnd[51:30];

  // ---------------------------------------------------------------------------
  // Grid memory and cell arithmetic
  // ---------------------------------------------------------------------------
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [15:0]        ram_wdata, ram_rdata;
  logic signed [16:0] upd_sum;
  logic signed [15:0] upd_val;
  logic               upd_clip;

  assign upd_sum  = 17'($signed(ram_rdata)) +
                    17'((state_q == S_HUPD) ? hit_upd_q : free_upd_q);
  assign upd_clip = upd_sum[16] != upd_sum[15];
  assign upd_val  = upd_clip ? (upd_sum[16] ? 16'sh8000 : 16'sh7FFF) : upd_sum[15:0];

  // current marched cell
  logic          cur_in, end_in, qry_in;
  logic [AW-1:0] cur_addr, end_addr, qry_addr;

  assign cur_in   = !col_q[CW-1] && (col_q < CW'(GRID_COLS)) &&
                    !row_q[CW-1] && (row_q < CW'(GRID_ROWS));
  assign cur_addr = AW'(row_q) * AW'(GRID_COLS) + AW'(col_q);
  assign end_in   = !ecol_q[QW-1] && (ecol_q < QW'(GRID_COLS)) &&
                    !erow_q[QW-1] && (erow_q < QW'(GRID_ROWS));
  assign end_addr = AW'(erow_q) * AW'(GRID_COLS) + AW'(ecol_q);
  assign qry_in   = ({26'b0, query_col_i} < 32'(GRID_COLS)) &&
                    ({26'b0, query_row_i} < 32'(GRID_ROWS));
  assign qry_addr = AW'(query_row_i) * AW'(GRID_COLS) + AW'(query_col_i);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr_q;
    ram_wdata = upd_val;
    case (state_q)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
      end
      S_MUPD, S_HUPD: ram_we = 1'b1;
      default: ram_we = 1'b0;
    endcase
  end

  always_comb begin
    case (state_q)
      S_IDLE:  ram_raddr = qry_addr;
      S_HIT:   ram_raddr = end_addr;
      default: ram_raddr = cur_addr;
    endcase
  end

  lorc_ram #(
    .Width(16),
    .Depth(Depth)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // point advance: col += q + carry, remainder stays in [0, size)
  logic [16:0]        sumx, sumy;
  logic               carx, cary;
  logic signed [CW-1:0] col_nx, row_nx;
  logic [15:0]        remx_nx, remy_nx;

  assign sumx    = {1'b0, remx_q} + {1'b0, rdx_q};
  assign sumy    = {1'b0, remy_q} + {1'b0, rdy_q};
  assign carx    = sumx >= {1'b0, size_eff};
  assign cary    = sumy >= {1'b0, size_eff};
  assign remx_nx = carx ? 16'(sumx - {1'b0, size_eff}) : sumx[15:0];
  assign remy_nx = cary ? 16'(sumy - {1'b0, size_eff}) : sumy[15:0];
  assign col_nx  = col_q + CW'(qdx_q) + CW'({1'b0, carx});
  assign row_nx  = row_q + CW'(qdy_q) + CW'({1'b0, cary});

  assign in_ready_o   = (state_q == S_IDLE);
  assign cordic_start = (state_q == S_IDLE) && in_valid_i && (req_type_i == REQ_RAY);

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q  <= 16'd512;
      march_step_q <= 16'd102;
      corner_x_q   <= -32'sd16384;
      corner_y_q   <= -32'sd16384;
      free_upd_q   <= -16'sd217;
      hit_upd_q    <= 16'sd355;
      free_thr_q   <= -16'sd355;
      hit_thr_q    <= 16'sd217;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CELL_SIZE:  cell_size_q  <= cfg_data_i[15:0];
        CFG_MARCH_STEP: march_step_q <= cfg_data_i[15:0];
        CFG_CORNER_X:   corner_x_q   <= cfg_data_i;
        CFG_CORNER_Y:   corner_y_q   <= cfg_data_i;
        CFG_FREE_UPD:   free_upd_q   <= cfg_data_i[15:0];
        CFG_HIT_UPD:    hit_upd_q    <= cfg_data_i[15:0];
        CFG_FREE_THR:   free_thr_q   <= cfg_data_i[15:0];
        CFG_HIT_THR:    hit_thr_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      init_q       <= 1'b1;
      clr_cnt_q    <= '0;
      mul_cnt_q    <= '0;
      div_cnt_q    <= '0;
      prev_valid_q <= 1'b0;
      out_valid_o  <= 1'b0;
    end else begin
      // S_DONE reloads the output register itself
      if (out_valid_o && out_ready_i && (state_q != S_DONE)) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          if (clr_cnt_q == AW'(Depth - 1)) begin
            clr_cnt_q <= '0;
            init_q    <= 1'b0;
            state_q   <= init_q ? S_IDLE : S_DONE;
          end else begin
            clr_cnt_q <= clr_cnt_q + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            res_class_q <= ((req_type_i == REQ_READ) && !qry_in) ? CLS_UNKNOWN : CLS_FREE;
            res_lo_q    <= '0;
            res_out_q   <= 1'b0;
            res_sat_q   <= 1'b0;
            ox_q        <= origin_x_i;
            oy_q        <= origin_y_i;
            range_q     <= ray_range_i;
            case (req_type_i)
              REQ_RAY:   state_q <= S_CORDIC;
              REQ_READ: begin
                if (qry_in) begin
                  state_q <= S_READ;
                end else begin
                  state_q <= S_DONE;
                end
              end
              REQ_CLEAR: state_q <= S_CLR;
              default:   state_q <= S_DONE;
            endcase
          end
        end
        S_CORDIC: begin
          if (cordic_res.done) begin
            cos_q     <= cordic_res.cos_q30;
            sin_q     <= cordic_res.sin_q30;
            mul_cnt_q <= '0;
            state_q   <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= mul_a * mul_b;
          state_q <= S_MULW;
        end
        S_MULW: begin
          case (mul_cnt_q)
            2'd0:    dx_q <= scaled;
            2'd1:    dy_q <= scaled;
            2'd2:    ex_q <= scaled;
            default: ey_q <= scaled;
          endcase
          mul_cnt_q <= mul_cnt_q + 2'd1;
          if (mul_cnt_q == 2'd3) begin
            div_cnt_q <= '0;
            state_q   <= S_DIV_GO;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_DIV_GO: state_q <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_res.done) begin
            case (div_cnt_q)
              3'd0: begin
                col_q  <= CW'(div_res.quot);
                remx_q <= div_res.rem;
              end
              3'd1: begin
                row_q  <= CW'(div_res.quot);
                remy_q <= div_res.rem;
              end
              3'd2: begin
                qdx_q <= div_res.quot;
                rdx_q <= div_res.rem;
              end
              3'd3: begin
                qdy_q <= div_res.quot;
                rdy_q <= div_res.rem;
              end
              3'd4:    ecol_q <= div_res.quot;
              default: erow_q <= div_res.quot;
            endcase
            div_cnt_q <= div_cnt_q + 3'd1;
            if (div_cnt_q == 3'd5) begin
              dist_q       <= '0;
              prev_valid_q <= 1'b0;
              state_q      <= S_MARCH;
            end else begin
              state_q <= S_DIV_GO;
            end
          end
        end
        S_MARCH: begin
          if (dist_q >= {1'b0, range_q}) begin
            state_q <= S_HIT;
          end else begin
            if (cur_in) begin
              prev_valid_q <= 1'b1;
              prev_addr_q  <= cur_addr;
            end else begin
              prev_valid_q <= 1'b0;
            end
            if (cur_in && (!prev_valid_q || prev_addr_q != cur_addr)) begin
              // fresh cell: read now, add free update next cycle
              cur_addr_q <= cur_addr;
              state_q    <= S_MUPD;
            end else begin
              col_q  <= col_nx;
              row_q  <= row_nx;
              remx_q <= remx_nx;
              remy_q <= remy_nx;
              dist_q <= dist_q + {2'b0, step_eff};
            end
          end
        end
        S_MUPD: begin
          if (upd_clip) begin
            res_sat_q <= 1'b1;
          end
          col_q   <= col_nx;
          row_q   <= row_nx;
          remx_q  <= remx_nx;
          remy_q  <= remy_nx;
          dist_q  <= dist_q + {2'b0, step_eff};
          state_q <= S_MARCH;
        end
        S_HIT: begin
          if (end_in) begin
            cur_addr_q <= end_addr;
            state_q    <= S_HUPD;
          end else begin
            res_out_q <= 1'b1;
            state_q   <= S_DONE;
          end
        end
        S_HUPD: begin
          if (upd_clip) begin
            res_sat_q <= 1'b1;
          end
          state_q <= S_DONE;
        end
        S_READ: begin
          res_lo_q <= ram_rdata;
          if ($signed(ram_rdata) <= free_thr_q) begin
            res_class_q <= CLS_FREE;
          end else if ($signed(ram_rdata) >= hit_thr_q) begin
            res_class_q <= CLS_OCC;
          end else begin
            res_class_q <= CLS_UNKNOWN;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o        <= 1'b1;
            cell_class_o       <= res_class_q;
            cell_logodds_o     <= res_lo_q;
            endpoint_outside_o <= res_out_q;
            saturated_o        <= res_sat_q;
            state_q            <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lorc_checker.sv
// ----------------------------------------------------------------------------
// lorc_checker
// Port-level checks for the occupancy ray update core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module lorc_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [1:0]         cell_class_o,
  input wire logic signed [15:0] cell_logodds_o,
  input wire logic               endpoint_outside_o,
  input wire logic               saturated_o
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cell_class_o) &&
    $stable(cell_logodds_o) && $stable(endpoint_outside_o) && $stable(saturated_o))
    else $error("result changed while stalled");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after accept");

  // read results (nonzero class or log-odds) carry no ray flags
  a_read_no_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cell_class_o != 2'd0 || cell_logodds_o != 16'sd0) |->
    !endpoint_outside_o && !saturated_o)
    else $error("ray flags on a read result");

  a_class_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cell_class_o != 2'd3)
    else $error("unused class code");

endmodule

bind logodds_occupancy_ray_update_core lorc_checker u_lorc_checker (.*);

`default_nettype wire
